// ----- hdl/exposed_voxel_scan_top_macros.svh -----
// Assertion macros for the exposed voxel scan checker.
// Expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef EXPOSED_VOXEL_SCAN_TOP_MACROS_SVH
`define EXPOSED_VOXEL_SCAN_TOP_MACROS_SVH

// property must hold at every edge outside reset
`define EVS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition must never be seen outside reset
`define EVS_ASSERT_NEVER(label, cond, msg) \
    `EVS_ASSERT(label, !(cond), msg)

`endif

// ----- hdl/evs_pkg.sv -----
// Shared types and constants for the exposed voxel scan block.
// No dependencies; used by every module of the block.
`default_nettype none

package evs_pkg;

    localparam int SECTION_SIDE = 16;
    localparam int PLANE_SIZE   = SECTION_SIDE * SECTION_SIDE;
    localparam int WIN_LEN      = 2 * PLANE_SIZE;
    localparam int XW           = $clog2(SECTION_SIDE);
    localparam int YW           = $clog2(SECTION_SIDE + 1);

    // window taps: win[k] holds the occupancy of position n-1-k
    localparam int TAP_XP = PLANE_SIZE - 2;
    localparam int TAP_C  = PLANE_SIZE - 1;
    localparam int TAP_XM = PLANE_SIZE;
    localparam int TAP_ZP = PLANE_SIZE - SECTION_SIDE - 1;
    localparam int TAP_ZM = PLANE_SIZE + SECTION_SIDE - 1;
    localparam int TAP_YM = 2 * PLANE_SIZE - 1;

    localparam int VOXEL_ID_W = 8;
    localparam int CHUNK_W    = 17;
    localparam int SECTION_W  = 8;
    localparam int WORLD_XZ_W = 21;
    localparam int WORLD_Y_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_Z   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTION_Y = 2'd2;

    localparam logic MODE_VOXEL = 1'b0;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef struct packed {
        logic [XW-1:0] lx;
        logic [XW-1:0] ly;
        logic [XW-1:0] lz;
    } coord_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ----- hdl/evs_front.sv -----
// Front end: occupancy shift window, position counters and exposure verdict.
// Depends on evs_pkg.
`default_nettype none

module evs_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               accept,
    input  wire logic                               mode,
    input  wire logic [evs_pkg::VOXEL_ID_W-1:0]     voxel_id,
    output logic                                    push,
    output evs_pkg::coord_t                         push_coord
);

    logic [evs_pkg::XW-1:0] x_reg, x_next;
    logic [evs_pkg::XW-1:0] z_reg, z_next;
    logic [evs_pkg::YW-1:0] y_reg, y_next;
    logic                   win_reg [evs_pkg::WIN_LEN];
    logic                   occ;
    logic                   judged;
    logic                   exposed;

    localparam logic [evs_pkg::XW-1:0] X_LAST = evs_pkg::XW'(evs_pkg::SECTION_SIDE - 1);
    localparam logic [evs_pkg::YW-1:0] Y_LAST = evs_pkg::YW'(evs_pkg::SECTION_SIDE);
    localparam logic [evs_pkg::YW-1:0] Y_ONE  = evs_pkg::YW'(1);

    assign occ = (mode == evs_pkg::MODE_VOXEL) && (voxel_id != '0);

    // position of the incoming item; y runs one plane past the section for flush
    always_comb begin
        x_next = x_reg;
        z_next = z_reg;
        y_next = y_reg;
        if (accept) begin
            if (x_reg == X_LAST) begin
                x_next = '0;
                if (z_reg == X_LAST) begin
                    z_next = '0;
                    y_next = (y_reg == Y_LAST) ? '0 : y_reg + Y_ONE;
                end else begin
                    z_next = z_reg + 1'b1;
                end
            end else begin
                x_next = x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            z_reg <= '0;
            y_reg <= '0;
        end else begin
            x_reg <= x_next;
            z_reg <= z_next;
            y_reg <= y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg[0] <= occ;
            for (int k = 1; k < evs_pkg::WIN_LEN; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    // judged voxel sits one plane behind the incoming item; the item itself is the +y face
    assign judged = (y_reg != '0);

    always_comb begin
        exposed = 1'b0;
        if (win_reg[evs_pkg::TAP_C]) begin
            exposed = (x_reg == X_LAST) || !win_reg[evs_pkg::TAP_XP]
                   || (x_reg == '0)     || !win_reg[evs_pkg::TAP_XM]
                   || (z_reg == X_LAST) || !win_reg[evs_pkg::TAP_ZP]
                   || (z_reg == '0)     || !win_reg[evs_pkg::TAP_ZM]
                   || (y_reg == Y_LAST) || !occ
                   || (y_reg == Y_ONE)  || !win_reg[evs_pkg::TAP_YM];
        end
    end

    assign push          = accept && judged && exposed;
    assign push_coord.lx = x_reg;
    assign push_coord.lz = z_reg;
    assign push_coord.ly = evs_pkg::XW'(y_reg - Y_ONE);

endmodule

`default_nettype wire

// ----- hdl/evs_queue.sv -----
// Short FIFO of exposed voxel coordinates between front and back.
// Depends on evs_pkg.
`default_nettype none

module evs_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  evs_pkg::coord_t    push_coord,
    input  wire logic          pop,
    output evs_pkg::coord_t    pop_coord,
    output evs_pkg::q_status_t status
);

    evs_pkg::coord_t              mem_reg [evs_pkg::QUEUE_DEPTH];
    logic [evs_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [evs_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [evs_pkg::QUEUE_AW:0]   count_reg, count_next;

    localparam logic [evs_pkg::QUEUE_AW:0] FULL_COUNT =
        (evs_pkg::QUEUE_AW + 1)'(evs_pkg::QUEUE_DEPTH);

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_coord;
        end
    end

    assign pop_coord    = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_COUNT);
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- hdl/evs_back.sv -----
// Back end: configuration registers, world coordinate adders, output register.
// Depends on evs_pkg.
`default_nettype none

module evs_back (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_write,
    input  wire logic [evs_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [evs_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  evs_pkg::q_status_t                          q_status,
    input  evs_pkg::coord_t                             q_coord,
    output logic                                        q_pop,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [evs_pkg::WORLD_XZ_W-1:0]       m_world_x,
    output logic signed [evs_pkg::WORLD_Y_W-1:0]        m_world_y,
    output logic signed [evs_pkg::WORLD_XZ_W-1:0]       m_world_z
);

    logic signed [evs_pkg::CHUNK_W-1:0]    chunk_x_reg, chunk_z_reg;
    logic signed [evs_pkg::SECTION_W-1:0]  section_y_reg;
    logic                                  valid_reg, valid_next;
    logic signed [evs_pkg::WORLD_XZ_W-1:0] world_x_reg, world_x_next;
    logic signed [evs_pkg::WORLD_Y_W-1:0]  world_y_reg, world_y_next;
    logic signed [evs_pkg::WORLD_XZ_W-1:0] world_z_reg, world_z_next;
    logic signed [evs_pkg::WORLD_XZ_W-1:0] chunk_x_ext, chunk_z_ext;
    logic signed [evs_pkg::WORLD_Y_W-1:0]  section_y_ext;

    localparam logic signed [evs_pkg::WORLD_XZ_W-1:0] SCALE_XZ =
        evs_pkg::WORLD_XZ_W'(evs_pkg::SECTION_SIDE);
    localparam logic signed [evs_pkg::WORLD_Y_W-1:0] SCALE_Y =
        evs_pkg::WORLD_Y_W'(evs_pkg::SECTION_SIDE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_x_reg   <= '0;
            chunk_z_reg   <= '0;
            section_y_reg <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                evs_pkg::CFG_CHUNK_X:   chunk_x_reg   <= cfg_data;
                evs_pkg::CFG_CHUNK_Z:   chunk_z_reg   <= cfg_data;
                evs_pkg::CFG_SECTION_Y: section_y_reg <= cfg_data[evs_pkg::SECTION_W-1:0];
                default: ;
            endcase
        end
    end

    assign chunk_x_ext   = evs_pkg::WORLD_XZ_W'(chunk_x_reg);
    assign chunk_z_ext   = evs_pkg::WORLD_XZ_W'(chunk_z_reg);
    assign section_y_ext = evs_pkg::WORLD_Y_W'(section_y_reg);

    // output register refills whenever it is empty or being drained
    assign q_pop = !q_status.empty && (!valid_reg || m_ready);

    always_comb begin
        valid_next   = valid_reg;
        world_x_next = world_x_reg;
        world_y_next = world_y_reg;
        world_z_next = world_z_reg;
        if (q_pop) begin
            valid_next   = 1'b1;
            world_x_next = evs_pkg::WORLD_XZ_W'(chunk_x_ext * SCALE_XZ)
                         + evs_pkg::WORLD_XZ_W'(q_coord.lx);
            world_y_next = evs_pkg::WORLD_Y_W'(section_y_ext * SCALE_Y)
                         + evs_pkg::WORLD_Y_W'(q_coord.ly);
            world_z_next = evs_pkg::WORLD_XZ_W'(chunk_z_ext * SCALE_XZ)
                         + evs_pkg::WORLD_XZ_W'(q_coord.lz);
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        world_x_reg <= world_x_next;
        world_y_reg <= world_y_next;
        world_z_reg <= world_z_next;
    end

    assign m_valid   = valid_reg;
    assign m_world_x = world_x_reg;
    assign m_world_y = world_y_reg;
    assign m_world_z = world_z_reg;

endmodule

`default_nettype wire

// ----- hdl/exposed_voxel_scan_top.sv -----
// Exposed voxel scan: one item per cycle; the verdict for a voxel is formed when the
// item one plane (256 items) later is accepted, and is queued, then registered onto m_*.
// s_ready stays high unless four results are queued behind a stalled output register.
// Configuration writes take effect in the next cycle; cfg_ready is always high.
// Synchronous active-low reset clears the position counters, queue and output valid;
// the occupancy window needs no clearing since only current-section bits are read.
`default_nettype none

module exposed_voxel_scan_top (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_mode,
    input  wire logic [evs_pkg::VOXEL_ID_W-1:0]         s_voxel_id,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [evs_pkg::WORLD_XZ_W-1:0]       m_world_x,
    output logic signed [evs_pkg::WORLD_Y_W-1:0]        m_world_y,
    output logic signed [evs_pkg::WORLD_XZ_W-1:0]       m_world_z,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [evs_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [evs_pkg::CFG_DATA_W-1:0]         cfg_data
);

    logic               accept;
    logic               push;
    logic               pop;
    evs_pkg::coord_t    push_coord;
    evs_pkg::coord_t    pop_coord;
    evs_pkg::q_status_t q_status;

    assign s_ready   = !q_status.full;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    evs_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .mode       (s_mode),
        .voxel_id   (s_voxel_id),
        .push       (push),
        .push_coord (push_coord)
    );

    evs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_coord (push_coord),
        .pop        (pop),
        .pop_coord  (pop_coord),
        .status     (q_status)
    );

    evs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .q_coord   (pop_coord),
        .q_pop     (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_world_x (m_world_x),
        .m_world_y (m_world_y),
        .m_world_z (m_world_z)
    );

endmodule

`default_nettype wire

// ----- hdl/evs_checker.sv -----
// Port-level checker for exposed_voxel_scan_top, attached by bind.
// Depends on evs_pkg and exposed_voxel_scan_top_macros.svh.
`default_nettype none
`include "exposed_voxel_scan_top_macros.svh"

module evs_checker (
    input wire logic                                   aclk,
    input wire logic                                   aresetn,
    input wire logic                                   s_ready,
    input wire logic                                   m_valid,
    input wire logic                                   m_ready,
    input wire logic signed [evs_pkg::WORLD_XZ_W-1:0]  m_world_x,
    input wire logic signed [evs_pkg::WORLD_Y_W-1:0]   m_world_y,
    input wire logic signed [evs_pkg::WORLD_XZ_W-1:0]  m_world_z,
    input wire logic                                   cfg_ready
);

    // a stalled result keeps its transfer pending
    `EVS_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `EVS_ASSERT(a_out_stable,
        m_valid && !m_ready |=> $stable(m_world_x) && $stable(m_world_y) && $stable(m_world_z),
        "result changed while stalled")
    // input backpressure only arises behind a stalled output
    `EVS_ASSERT_NEVER(a_ready_low, !s_ready && !m_valid, "input stalled with output empty")
    `EVS_ASSERT_NEVER(a_cfg_ready, !cfg_ready, "configuration write refused")

endmodule

bind exposed_voxel_scan_top evs_checker u_evs_checker (.*);

`default_nettype wire
